[src/particle_sensor_frame_parser_macros.svh]
// ---------------------------------------------------------------------------
// Particle sensor frame parser assertion macros
// Shorthand for clocked concurrent assertions with synchronous reset masking.
// ---------------------------------------------------------------------------
`ifndef PARTICLE_SENSOR_FRAME_PARSER_MACROS_SVH
`define PARTICLE_SENSOR_FRAME_PARSER_MACROS_SVH

// Same-cycle implication, masked while reset is low.
`define PSFP_ASSERT_NOW(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is low.
`define PSFP_ASSERT_NXT(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/psfp_pkg.sv]
// ---------------------------------------------------------------------------
// Particle sensor frame parser package
// Shared item types, byte classes and frame constants.
// ---------------------------------------------------------------------------
package psfp_pkg;

  localparam logic [7:0]  HDR_FIRST   = 8'h42;
  localparam logic [7:0]  HDR_SECOND  = 8'h4D;
  localparam logic [15:0] LEN_EXPECT  = 16'd28;
  localparam logic [5:0]  FRAME_SIZE  = 6'd32;
  localparam logic [5:0]  COUNT_SAT   = 6'd33;
  localparam logic [5:0]  IDX_HDR1    = 6'd1;
  localparam logic [5:0]  IDX_LEN_LO  = 6'd3;
  localparam logic [5:0]  IDX_VAL_LO  = 6'd4;
  localparam logic [5:0]  IDX_VAL_HI  = 6'd15;
  localparam logic [5:0]  IDX_VER     = 6'd28;
  localparam logic [5:0]  IDX_ERR     = 6'd29;
  localparam logic [5:0]  IDX_CHK_HI  = 6'd30;
  localparam logic [5:0]  IDX_CHK_LO  = 6'd31;
  localparam int          NUM_WORDS   = 6;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_FRAME = 2'd1;
  localparam logic [1:0] ST_BAD_LEN   = 2'd2;
  localparam logic [1:0] ST_BAD_SUM   = 2'd3;

  typedef enum logic [3:0] {
    K_HDR0,
    K_HDR1,
    K_LEN,
    K_VALUE,
    K_SKIP,
    K_VER,
    K_ERR,
    K_CHK_HI,
    K_CHK_LO,
    K_EXTRA
  } kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] std_pm1;
    logic [15:0] std_pm2p5;
    logic [15:0] std_pm10;
    logic [15:0] atm_pm1;
    logic [15:0] atm_pm2p5;
    logic [15:0] atm_pm10;
    logic [7:0]  sensor_version;
    logic [7:0]  sensor_error;
  } out_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
    kind_t      kind;
    logic [2:0] slot;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[src/psfp_queue.sv]
// ---------------------------------------------------------------------------
// Classified byte queue
// Small register FIFO between the classifying front and the executing back.
// ---------------------------------------------------------------------------
module psfp_queue #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  psfp_pkg::q_entry_t push_data,
  input  logic               pop,
  output psfp_pkg::q_entry_t head,
  output psfp_pkg::q_stat_t  stat
);
  import psfp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  q_entry_t         mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign head       = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == CNT_FULL);
  assign stat.empty = (cnt_r == '0);

endmodule

[src/psfp_front.sv]
// ---------------------------------------------------------------------------
// Frame parser front
// Accepts bytes, tracks the byte position and tags each byte with its role.
// ---------------------------------------------------------------------------
module psfp_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  psfp_pkg::in_item_t in_data,
  input  psfp_pkg::q_stat_t  q_stat,
  output logic               push,
  output psfp_pkg::q_entry_t push_data
);
  import psfp_pkg::*;

  logic [5:0] idx_r, idx_nxt;
  logic [5:0] val_off;

  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;
  assign val_off  = idx_r - IDX_VAL_LO;

  // Classify the byte by its position in the buffer.
  always_comb begin
    push_data.data_byte = in_data.data_byte;
    push_data.frame_end = in_data.frame_end;
    push_data.slot      = val_off[3:1];
    if (idx_r >= FRAME_SIZE) begin
      push_data.kind = K_EXTRA;
    end else if (idx_r == '0) begin
      push_data.kind = K_HDR0;
    end else if (idx_r == IDX_HDR1) begin
      push_data.kind = K_HDR1;
    end else if (idx_r <= IDX_LEN_LO) begin
      push_data.kind = K_LEN;
    end else if (idx_r <= IDX_VAL_HI) begin
      push_data.kind = K_VALUE;
    end else if (idx_r < IDX_VER) begin
      push_data.kind = K_SKIP;
    end else if (idx_r == IDX_VER) begin
      push_data.kind = K_VER;
    end else if (idx_r == IDX_ERR) begin
      push_data.kind = K_ERR;
    end else if (idx_r == IDX_CHK_HI) begin
      push_data.kind = K_CHK_HI;
    end else begin
      push_data.kind = K_CHK_LO;
    end
  end

  // Restart on the last byte, otherwise advance and saturate past the frame.
  always_comb begin
    idx_nxt = idx_r;
    if (push) begin
      if (in_data.frame_end) begin
        idx_nxt = '0;
      end else if (idx_r < COUNT_SAT) begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  // Positions past IDX_CHK_LO are all folded into K_EXTRA above.
  logic unused_idx;
  assign unused_idx = ^{val_off[5:4], val_off[0], IDX_CHK_LO};

endmodule

[src/psfp_back.sv]
// ---------------------------------------------------------------------------
// Frame parser back
// Executes classified bytes: sum, header check, capture, and result issue.
// ---------------------------------------------------------------------------
module psfp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  psfp_pkg::q_stat_t   q_stat,
  input  psfp_pkg::q_entry_t  head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output psfp_pkg::out_item_t out_data
);
  import psfp_pkg::*;

  logic [15:0] sum_r, sum_nxt;
  logic        hdr_good_r, hdr_good_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] value_r [NUM_WORDS];
  logic [15:0] value_nxt [NUM_WORDS];
  logic [7:0]  ver_r, ver_nxt;
  logic [7:0]  err_r, err_nxt;
  logic [7:0]  chk_hi_r, chk_hi_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;
  logic        out_free;
  logic [1:0]  status;

  assign out_free = !out_valid_r || !out_stall;
  // Hold a last byte in the queue until the output register can take it.
  assign pop = !q_stat.empty && (!head.frame_end || out_free);

  always_comb begin
    if (!hdr_good_r || head.kind != K_CHK_LO) begin
      status = ST_BAD_FRAME;
    end else if (len_r != LEN_EXPECT) begin
      status = ST_BAD_LEN;
    end else if (sum_r != {chk_hi_r, head.data_byte}) begin
      status = ST_BAD_SUM;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    sum_nxt       = sum_r;
    hdr_good_nxt  = hdr_good_r;
    len_nxt       = len_r;
    value_nxt     = value_r;
    ver_nxt       = ver_r;
    err_nxt       = err_r;
    chk_hi_nxt    = chk_hi_r;
    out_valid_nxt = out_free ? 1'b0 : out_valid_r;
    out_data_nxt  = out_data_r;
    if (pop) begin
      if (head.kind != K_CHK_HI && head.kind != K_CHK_LO && head.kind != K_EXTRA) begin
        sum_nxt = sum_r + {8'd0, head.data_byte};
      end
      case (head.kind)
        K_HDR0: begin
          if (head.data_byte != HDR_FIRST) hdr_good_nxt = 1'b0;
        end
        K_HDR1: begin
          if (head.data_byte != HDR_SECOND) hdr_good_nxt = 1'b0;
        end
        K_LEN:    len_nxt = {len_r[7:0], head.data_byte};
        K_VALUE:  value_nxt[head.slot] = {value_r[head.slot][7:0], head.data_byte};
        K_VER:    ver_nxt = head.data_byte;
        K_ERR:    err_nxt = head.data_byte;
        K_CHK_HI: chk_hi_nxt = head.data_byte;
        default: ;
      endcase
      if (head.frame_end) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = '0;
        out_data_nxt.status = status;
        if (status == ST_OK) begin
          out_data_nxt.std_pm1        = value_r[0];
          out_data_nxt.std_pm2p5      = value_r[1];
          out_data_nxt.std_pm10       = value_r[2];
          out_data_nxt.atm_pm1        = value_r[3];
          out_data_nxt.atm_pm2p5      = value_r[4];
          out_data_nxt.atm_pm10       = value_r[5];
          out_data_nxt.sensor_version = ver_r;
          out_data_nxt.sensor_error   = err_r;
        end
        // Drop the frame state for the next buffer.
        sum_nxt      = '0;
        hdr_good_nxt = 1'b1;
        len_nxt      = '0;
        for (int i = 0; i < NUM_WORDS; i++) begin
          value_nxt[i] = '0;
        end
        ver_nxt    = '0;
        err_nxt    = '0;
        chk_hi_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      hdr_good_r  <= 1'b1;
      len_r       <= '0;
      for (int i = 0; i < NUM_WORDS; i++) begin
        value_r[i] <= '0;
      end
      ver_r       <= '0;
      err_r       <= '0;
      chk_hi_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r       <= sum_nxt;
      hdr_good_r  <= hdr_good_nxt;
      len_r       <= len_nxt;
      value_r     <= value_nxt;
      ver_r       <= ver_nxt;
      err_r       <= err_nxt;
      chk_hi_r    <= chk_hi_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[src/particle_sensor_frame_parser.sv]
// The front writes each accepted byte into the queue, and the back executes it
// from the queue head; executing a frame's last byte registers its result.
// Throughput: one byte per cycle; the front stalls only when the queue is full,
// which happens while a finished result waits under out_stall.
// Reset: synchronous active-low rst_n clears the byte position, queue,
// frame state and result valid; no clearing pass is needed.
// ---------------------------------------------------------------------------
// Particle sensor frame parser
// Parses the 32-byte particle sensor frame byte by byte and reports status,
// the six mass-concentration words, and the version and error bytes.
// ---------------------------------------------------------------------------
module particle_sensor_frame_parser #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  psfp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output psfp_pkg::out_item_t out_data
);
  import psfp_pkg::*;

  // Front to queue: classified request plus queue status back.
  logic     push;
  q_entry_t push_data;
  q_stat_t  q_stat;

  // Queue to back: head request and its release.
  logic     pop;
  q_entry_t head;

  // Front: accept bytes, track the position in the buffer, tag each byte.
  // The position restarts on the flagged last byte, so classification never
  // waits on the back.
  psfp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  // Queue: decouple the two halves so that an output stall holds only the
  // last byte of a frame while later bytes keep arriving until the queue fills.
  psfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  // Back: accumulate the checksum, check header and length, capture values,
  // and issue one result into the output register on the last byte.
  psfp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[src/psfp_checker.sv]
// ---------------------------------------------------------------------------
// Frame parser port checker
// Watches the top-level ports for result and back-pressure consistency.
// ---------------------------------------------------------------------------
`include "particle_sensor_frame_parser_macros.svh"

module psfp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input psfp_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input psfp_pkg::out_item_t out_data
);
  import psfp_pkg::*;

  logic fail_zero;
  logic unused_in;

  assign fail_zero = (out_data.std_pm1 == '0) && (out_data.std_pm2p5 == '0) &&
                     (out_data.std_pm10 == '0) && (out_data.atm_pm1 == '0) &&
                     (out_data.atm_pm2p5 == '0) && (out_data.atm_pm10 == '0) &&
                     (out_data.sensor_version == '0) && (out_data.sensor_error == '0);
  assign unused_in = ^{in_valid, in_data};

  `PSFP_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "result dropped under stall")
  `PSFP_ASSERT_NOW(a_stall_pending, clk, rst_n, in_stall, out_valid, "input stalled with no result pending")
  `PSFP_ASSERT_NOW(a_fail_zero, clk, rst_n, out_valid && (out_data.status != ST_OK), fail_zero, "failed frame carries values")

endmodule

bind particle_sensor_frame_parser psfp_checker u_psfp_checker (.*);

[tb/particle_sensor_frame_parser_tb.sv]
// ---------------------------------------------------------------------------
// Particle sensor frame parser testbench
// Streams short and full sensor buffers into the parser: a table of directed
// short buffers first, then random frames (good, bad length, bad checksum,
// bad header, short, long and noise). An in-bench model predicts each random
// report. Every accepted report is checked field by field, in order.
// ---------------------------------------------------------------------------
module particle_sensor_frame_parser_tb;
  import psfp_pkg::*;

  localparam int ITEM_TARGET = 1400;  // requests to send in total
  localparam int QUIET_TAIL  = 150;   // last requests, sent without idling
  localparam int HOLD_CYCLES = 1500;  // one long receiver hold-off

  typedef logic [7:0] byte_list_t[$];

  typedef enum int {
    FR_GOOD,
    FR_BAD_LEN,
    FR_BAD_SUM,
    FR_BAD_HDR,
    FR_SHORT,
    FR_LONG,
    FR_NOISE
  } buffer_kind_t;

  // One directed row: the request and, where obvious, its report.
  typedef struct packed {
    in_item_t  req;
    logic      typed;
    out_item_t want;
  } dir_row_t;

  // Any failed frame reports its status with every value field cleared.
  localparam out_item_t FRAME_REJECT = '{ST_BAD_FRAME, 16'h0, 16'h0, 16'h0,
                                         16'h0, 16'h0, 16'h0, 8'h0, 8'h0};

  // Short buffers right after reset: lone bytes at both extremes, a good
  // header cut short, bad first and second header bytes, and a good header
  // and length word that still end far too early.
  localparam dir_row_t DIRECTED_ROWS [18] = '{
    '{'{8'h00, 1'b1}, 1'b1, FRAME_REJECT},
    '{'{8'hFF, 1'b1}, 1'b1, FRAME_REJECT},
    '{'{8'h42, 1'b1}, 1'b1, FRAME_REJECT},
    '{'{8'h42, 1'b0}, 1'b0, '0},
    '{'{8'h4D, 1'b1}, 1'b1, FRAME_REJECT},
    '{'{8'h42, 1'b0}, 1'b0, '0},
    '{'{8'h4C, 1'b0}, 1'b0, '0},
    '{'{8'h1C, 1'b1}, 1'b1, FRAME_REJECT},
    '{'{8'h43, 1'b0}, 1'b0, '0},
    '{'{8'h4D, 1'b0}, 1'b0, '0},
    '{'{8'h00, 1'b0}, 1'b0, '0},
    '{'{8'h1C, 1'b1}, 1'b1, FRAME_REJECT},
    '{'{8'h42, 1'b0}, 1'b0, '0},
    '{'{8'h4D, 1'b0}, 1'b0, '0},
    '{'{8'h00, 1'b0}, 1'b0, '0},
    '{'{8'h1C, 1'b0}, 1'b0, '0},
    '{'{8'hFF, 1'b0}, 1'b0, '0},
    '{'{8'h00, 1'b1}, 1'b1, FRAME_REJECT}
  };

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // Frame model state, mirrors what the parser holds between bytes.
  logic [5:0]  frame_pos;
  logic [15:0] frame_sum;
  logic        hdr_ok;
  logic [15:0] len_word;
  logic [15:0] conc_words [NUM_WORDS];
  logic [7:0]  ver_byte;
  logic [7:0]  err_byte;
  logic [7:0]  chk_hi;

  out_item_t pending_readings[$];  // reports predicted but not yet seen
  int        error_count    = 0;
  int        items_accepted = 0;
  int        idle_odds      = 6;   // 1 in idle_odds chance of a burst, 0 = none
  bit        hold_request   = 1'b0;

  particle_sensor_frame_parser i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the parser hangs.
  initial begin
    #6000000;
    $display("simulation failed");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Frame model
  // -------------------------------------------------------------------------

  function automatic void clear_frame();
    frame_pos = '0;
    frame_sum = '0;
    hdr_ok    = 1'b1;
    len_word  = '0;
    for (int w = 0; w < NUM_WORDS; w++) conc_words[w] = '0;
    ver_byte  = '0;
    err_byte  = '0;
    chk_hi    = '0;
  endfunction

  // Advance the model by one byte; return 1 and fill reading when the byte
  // closes a buffer.
  function automatic bit parse_frame_byte(input in_item_t req, output out_item_t reading);
    logic [5:0] pos;
    logic [7:0] b;
    logic [1:0] verdict;
    int         w;
    pos     = frame_pos;
    b       = req.data_byte;
    reading = '0;
    if (pos < FRAME_SIZE) begin
      // Bytes 0..29 go into the checksum; the check word itself does not.
      if (pos < IDX_CHK_HI) frame_sum = frame_sum + b;
      if (pos == 6'd0) begin
        if (b != HDR_FIRST) hdr_ok = 1'b0;
      end else if (pos == IDX_HDR1) begin
        if (b != HDR_SECOND) hdr_ok = 1'b0;
      end else if (pos <= IDX_LEN_LO) begin
        len_word = {len_word[7:0], b};
      end else if (pos <= IDX_VAL_HI) begin
        w = int'(pos - IDX_VAL_LO) >> 1;
        conc_words[w] = {conc_words[w][7:0], b};
      end else if (pos == IDX_VER) begin
        ver_byte = b;
      end else if (pos == IDX_ERR) begin
        err_byte = b;
      end else if (pos == IDX_CHK_HI) begin
        chk_hi = b;
      end
    end
    // Hold the count at "more than 32" once it gets there.
    if (pos < COUNT_SAT) frame_pos = pos + 6'd1;
    if (!req.frame_end) return 1'b0;

    // Header and size first, then the length word, then the checksum.
    if (!hdr_ok || pos != IDX_CHK_LO) verdict = ST_BAD_FRAME;
    else if (len_word != LEN_EXPECT) verdict = ST_BAD_LEN;
    else if (frame_sum != {chk_hi, b}) verdict = ST_BAD_SUM;
    else verdict = ST_OK;

    reading.status = verdict;
    if (verdict == ST_OK) begin
      reading.std_pm1        = conc_words[0];
      reading.std_pm2p5      = conc_words[1];
      reading.std_pm10       = conc_words[2];
      reading.atm_pm1        = conc_words[3];
      reading.atm_pm2p5      = conc_words[4];
      reading.atm_pm10       = conc_words[5];
      reading.sensor_version = ver_byte;
      reading.sensor_error   = err_byte;
    end
    clear_frame();
    return 1'b1;
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------

  // Favor the extremes so that all-zero and all-one words show up often.
  function automatic logic [7:0] any_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic byte_list_t build_frame(buffer_kind_t kind);
    byte_list_t  bytes;
    logic [15:0] sum;
    logic [15:0] len;
    int          spot;
    int          keep;
    if (kind == FR_NOISE) begin
      repeat ($urandom_range(1, 40)) bytes.push_back(any_byte());
      return bytes;
    end
    for (int i = 0; i < 32; i++) bytes.push_back(any_byte());

    // Build a well-formed frame, then break what the kind calls for.
    len = LEN_EXPECT;
    if (kind == FR_BAD_LEN || (kind == FR_BAD_HDR && $urandom_range(0, 1) == 1)) begin
      len = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
      if (len == LEN_EXPECT) len = len ^ 16'h8000;
    end
    bytes[0] = HDR_FIRST;
    bytes[1] = HDR_SECOND;
    bytes[2] = len[15:8];
    bytes[3] = len[7:0];
    if (kind == FR_BAD_HDR) begin
      spot = $urandom_range(0, 1);
      bytes[spot] = bytes[spot] ^ 8'($urandom_range(1, 255));
    end

    sum = '0;
    for (int i = 0; i < 30; i++) sum = sum + bytes[i];
    bytes[30] = sum[15:8];
    bytes[31] = sum[7:0];
    // Corrupt the check word; bad length frames get it half the time so
    // that the length check is seen to win over the checksum.
    if (kind == FR_BAD_SUM || (kind == FR_BAD_LEN && $urandom_range(0, 1) == 1)) begin
      spot = $urandom_range(30, 31);
      bytes[spot] = bytes[spot] ^ 8'($urandom_range(1, 255));
    end

    if (kind == FR_SHORT) begin
      keep = $urandom_range(1, 31);
      while (bytes.size() > keep) void'(bytes.pop_back());
    end else if (kind == FR_LONG) begin
      repeat ($urandom_range(1, 40)) bytes.push_back(any_byte());
    end
    return bytes;
  endfunction

  // Offer one request, wait for the accept, then predict its report.
  task automatic send_byte(input in_item_t req, input logic typed, input out_item_t want);
    out_item_t reading;
    // Drop valid for a random burst now and then.
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_accepted++;
    if (parse_frame_byte(req, reading)) begin
      pending_readings.push_back(typed ? want : reading);
    end
  endtask

  // Send a buffer with the end flag on its last byte; scattered ends also
  // split it at random points.
  task automatic send_buffer(input byte_list_t bytes, input bit scatter);
    in_item_t req;
    for (int i = 0; i < bytes.size(); i++) begin
      req.data_byte = bytes[i];
      req.frame_end = (i == bytes.size() - 1) || (scatter && $urandom_range(0, 5) == 0);
      send_byte(req, 1'b0, '0);
    end
  endtask

  // -------------------------------------------------------------------------
  // Receiver: random stall bursts, plus one long hold-off on request so the
  // parser backs up and stalls its input.
  // -------------------------------------------------------------------------
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Report checker: compare each accepted report with the oldest prediction.
  // -------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_readings.size() == 0) begin
        $error("report with none pending: %0h", out_data);
        error_count++;
      end else begin
        want = pending_readings.pop_front();
        check_field("status",         16'(want.status),         16'(out_data.status));
        check_field("std_pm1",        want.std_pm1,             out_data.std_pm1);
        check_field("std_pm2p5",      want.std_pm2p5,           out_data.std_pm2p5);
        check_field("std_pm10",       want.std_pm10,            out_data.std_pm10);
        check_field("atm_pm1",        want.atm_pm1,             out_data.atm_pm1);
        check_field("atm_pm2p5",      want.atm_pm2p5,           out_data.atm_pm2p5);
        check_field("atm_pm10",       want.atm_pm10,            out_data.atm_pm10);
        check_field("sensor_version", 16'(want.sensor_version), 16'(out_data.sensor_version));
        check_field("sensor_error",   16'(want.sensor_error),   16'(out_data.sensor_error));
      end
    end
  end

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin : stimulus
    byte_list_t   bytes;
    buffer_kind_t kind;
    int           pick;
    clear_frame();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed short buffers; typed rows carry their own report.
    foreach (DIRECTED_ROWS[r]) begin
      send_byte(DIRECTED_ROWS[r].req, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
    end

    // Start the long receiver hold-off while frames keep coming.
    hold_request = 1'b1;

    while (items_accepted < ITEM_TARGET) begin
      // Pick the idling rate per buffer; run the tail with none.
      if (items_accepted > ITEM_TARGET - QUIET_TAIL) begin
        idle_odds = 0;
      end else begin
        case ($urandom_range(0, 3))
          0:       idle_odds = 0;
          1:       idle_odds = 3;
          2:       idle_odds = 8;
          default: idle_odds = 20;
        endcase
      end
      pick = $urandom_range(0, 99);
      if (pick < 45)      kind = FR_GOOD;
      else if (pick < 55) kind = FR_BAD_LEN;
      else if (pick < 70) kind = FR_BAD_SUM;
      else if (pick < 80) kind = FR_BAD_HDR;
      else if (pick < 88) kind = FR_SHORT;
      else if (pick < 95) kind = FR_LONG;
      else                kind = FR_NOISE;
      bytes = build_frame(kind);
      send_buffer(bytes, kind == FR_NOISE);
    end
    in_valid <= 1'b0;
    idle_odds = 0;

    // Drain the outstanding reports, then allow for the pipeline latency.
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[particle_sensor_frame_parser.f]
+incdir+src
src/psfp_pkg.sv
src/psfp_queue.sv
src/psfp_front.sv
src/psfp_back.sv
src/particle_sensor_frame_parser.sv
src/psfp_checker.sv
tb/particle_sensor_frame_parser_tb.sv
